// File: src/pva_pkg.sv
// Shared types, constants and tables for the phase vocoder analysis block.
// Used by every module in src; depends on nothing.
`default_nettype none
package pva_pkg;

  localparam int MAX_HALF_SIZE = 512;
  localparam int MEM_DEPTH     = MAX_HALF_SIZE + 1;
  localparam int MEM_AW        = $clog2(MEM_DEPTH);

  localparam int SAMP_W = 24;
  localparam int BIN_W  = 10;
  localparam int MAG_W  = 24;
  localparam int FREQ_W = 32;
  localparam int CFG_W  = 32;
  localparam int PH_W   = 16;
  localparam int CX_W   = 36;   // cordic x/y after the x256 prescale plus gain
  localparam int SQ_W   = 48;   // radicand re^2 + im^2
  localparam int REM_W  = 27;

  localparam int CORDIC_STEPS = 15;
  localparam int SQ_STEPS     = MAG_W;

  // pipeline register sets of the back end
  localparam int NSTAGE = 2 + SQ_STEPS;
  localparam int PH_RD  = 1 + CORDIC_STEPS;  // phase formed, memory read data lands
  localparam int PH_WR  = PH_RD + 1;         // phase advance, memory write
  localparam int MUL_ST = PH_WR + 1;
  localparam int FRQ_ST = MUL_ST + 1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  localparam logic [1:0] CFG_HALF_SIZE   = 2'd0;
  localparam logic [1:0] CFG_BIN_SPACING = 2'd1;
  localparam logic [1:0] CFG_ANGLE_TO_HZ = 2'd2;

  localparam logic [BIN_W-1:0] HALF_SIZE_RST   = BIN_W'(512);
  localparam logic [CFG_W-1:0] BIN_SPACING_RST = 32'd2822400;
  localparam logic [CFG_W-1:0] ANGLE_TO_HZ_RST = 32'd11289600;

  typedef struct packed {
    logic [BIN_W-1:0] half_size;
    logic [CFG_W-1:0] bin_spacing_hz;
    logic [CFG_W-1:0] angle_to_hz;
  } pva_cfg_t;

  typedef struct packed {
    logic [SAMP_W-1:0] re;
    logic [SAMP_W-1:0] im;    // already zeroed at DC and Nyquist
    logic [BIN_W-1:0]  bin;
    logic              last;
    logic              nz;    // vector is not zero
  } pva_item_t;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [FREQ_W-1:0] freq;
    logic [BIN_W-1:0]  bin;
    logic              last;
  } pva_result_t;

  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic              last;
    logic              nz;
    logic              inmem;
    logic [CX_W-1:0]   x;
    logic [CX_W-1:0]   y;
    logic [PH_W-1:0]   z;
    logic [SQ_W-2:0]   sq_a;
    logic [SQ_W-2:0]   sq_b;
    logic [SQ_W-1:0]   v;
    logic [REM_W-1:0]  rem;
    logic [MAG_W-1:0]  q;
    logic [PH_W-1:0]   phase;
    logic [PH_W-1:0]   diff;
    logic [PH_W+CFG_W:0] pa;
    logic [BIN_W+CFG_W-1:0] pb;
    logic [FREQ_W-1:0] freq;
  } pva_stage_t;

  // round(atan(2^-i) * 65536 / (2*pi))
  function automatic logic [PH_W-1:0] atan_unit(input logic [3:0] i);
    logic [PH_W-1:0] r;
    case (i)
      4'd0:    r = 16'd8192;
      4'd1:    r = 16'd4836;
      4'd2:    r = 16'd2555;
      4'd3:    r = 16'd1297;
      4'd4:    r = 16'd651;
      4'd5:    r = 16'd326;
      4'd6:    r = 16'd163;
      4'd7:    r = 16'd81;
      4'd8:    r = 16'd41;
      4'd9:    r = 16'd20;
      4'd10:   r = 16'd10;
      4'd11:   r = 16'd5;
      4'd12:   r = 16'd3;
      default: r = 16'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/pva_front.sv
// Front end: classifies incoming bins (DC/Nyquist masking, last flag) and
// queues them for the back end. Depends on pva_pkg.
`default_nettype none
module pva_front import pva_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [SAMP_W-1:0] real_part,
  input  logic [SAMP_W-1:0] imag_part,
  input  logic [BIN_W-1:0]  bin_index,
  input  logic [BIN_W-1:0]  half_size,
  input  logic              clr_busy,
  output logic              item_vld,
  output pva_item_t         item,
  input  logic              item_pop
);

  pva_item_t        q_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QCW-1:0]   cnt_r;
  pva_item_t        cls;
  logic             is_last, do_push, do_pop;

  always_comb begin
    is_last  = (bin_index == half_size);
    cls.re   = real_part;
    cls.im   = (bin_index == '0 || is_last) ? '0 : imag_part;
    cls.bin  = bin_index;
    cls.last = is_last;
    cls.nz   = (real_part != '0) || (cls.im != '0);
  end

  assign full     = (cnt_r == QCW'(QDEPTH)) || clr_busy;
  assign do_push  = push && !full;
  assign item_vld = (cnt_r != '0);
  assign do_pop   = item_pop && item_vld;
  assign item     = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + QAW'(1);
      if (do_pop)  rp_r <= rp_r + QAW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + QCW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= cls;
  end

endmodule
`default_nettype wire

// File: src/pva_back.sv
// Back end: squares + pipelined square root, pipelined CORDIC angle, phase
// memory with forwarding, frequency multiply and saturate. Depends on pva_pkg.
`default_nettype none
module pva_back import pva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pva_cfg_t    cfg,
  input  logic        item_vld,
  input  pva_item_t   item,
  output logic        item_pop,
  input  logic        res_room,
  output logic        res_push,
  output pva_result_t res,
  output logic        clr_busy
);

  pva_stage_t         st_r   [NSTAGE];
  pva_stage_t         st_nxt [NSTAGE];
  logic [NSTAGE-1:0]  vld_r;
  logic [PH_W-1:0]    mem [MEM_DEPTH];
  logic [PH_W-1:0]    rd_r, fwd_r;
  logic               fw_r;
  logic [MEM_AW-1:0]  clr_cnt_r;
  logic               clr_busy_r;
  logic               en, wr_cond, wr_en, fw_nxt;
  logic [MEM_AW-1:0]  rd_addr, wr_addr;

  // whole pipeline advances together whenever the result queue has room
  assign en       = res_room;
  assign item_pop = en && item_vld;
  assign clr_busy = clr_busy_r;

  assign rd_addr = st_r[PH_RD-1].bin[MEM_AW-1:0];
  assign wr_addr = st_r[PH_RD].bin[MEM_AW-1:0];
  assign wr_cond = vld_r[PH_RD] && st_r[PH_RD].nz && st_r[PH_RD].inmem;
  assign wr_en   = en && wr_cond;
  // item one stage behind reads the entry being written this edge
  assign fw_nxt  = wr_cond && (st_r[PH_RD-1].bin == st_r[PH_RD].bin);

  always_comb begin
    logic signed [SQ_W-1:0]   pr, pi;
    logic signed [CX_W-1:0]   xe, ye, xs, ys;
    logic [REM_W-1:0]         t, tr;
    logic [PH_W-1:0]          prev;
    logic signed [PH_W+CFG_W:0] pa_s;
    logic signed [PH_W+CFG_W+1:0] s;

    xs   = '0;
    ys   = '0;
    t    = '0;
    tr   = '0;
    prev = '0;
    pa_s = '0;
    s    = '0;

    // set 0: squares and cordic half-turn prerotation
    st_nxt[0]       = '0;
    pr              = $signed(item.re) * $signed(item.re);
    pi              = $signed(item.im) * $signed(item.im);
    st_nxt[0].sq_a  = pr[SQ_W-2:0];
    st_nxt[0].sq_b  = pi[SQ_W-2:0];
    xe              = {{(CX_W-SAMP_W-8){item.re[SAMP_W-1]}}, item.re, 8'h00};
    ye              = {{(CX_W-SAMP_W-8){item.im[SAMP_W-1]}}, item.im, 8'h00};
    st_nxt[0].bin   = item.bin;
    st_nxt[0].last  = item.last;
    st_nxt[0].nz    = item.nz;
    st_nxt[0].inmem = (item.bin <= BIN_W'(MAX_HALF_SIZE));
    if (xe < 0) begin
      st_nxt[0].x = -xe;
      st_nxt[0].y = -ye;
      st_nxt[0].z = 16'h8000;
    end else begin
      st_nxt[0].x = xe;
      st_nxt[0].y = ye;
      st_nxt[0].z = '0;
    end

    for (int k = 1; k < NSTAGE; k++) begin
      st_nxt[k] = st_r[k-1];
      // cordic micro-rotation k-1
      if (k <= CORDIC_STEPS) begin
        xs = $signed(st_r[k-1].x) >>> (k-1);
        ys = $signed(st_r[k-1].y) >>> (k-1);
        if ($signed(st_r[k-1].y) > 0) begin
          st_nxt[k].x = st_r[k-1].x + ys;
          st_nxt[k].y = st_r[k-1].y - xs;
          st_nxt[k].z = st_r[k-1].z + atan_unit(4'(k-1));
        end else begin
          st_nxt[k].x = st_r[k-1].x - ys;
          st_nxt[k].y = st_r[k-1].y + xs;
          st_nxt[k].z = st_r[k-1].z - atan_unit(4'(k-1));
        end
      end
      // square root: sum, then one result bit per stage
      if (k == 1) begin
        st_nxt[k].v   = {1'b0, st_r[k-1].sq_a} + {1'b0, st_r[k-1].sq_b};
        st_nxt[k].rem = '0;
        st_nxt[k].q   = '0;
      end else begin
        t  = {st_r[k-1].rem[REM_W-3:0], st_r[k-1].v[SQ_W-1 -: 2]};
        tr = {1'b0, st_r[k-1].q, 2'b01};
        st_nxt[k].v = {st_r[k-1].v[SQ_W-3:0], 2'b00};
        if (t >= tr) begin
          st_nxt[k].rem = t - tr;
          st_nxt[k].q   = {st_r[k-1].q[MAG_W-2:0], 1'b1};
        end else begin
          st_nxt[k].rem = t;
          st_nxt[k].q   = {st_r[k-1].q[MAG_W-2:0], 1'b0};
        end
      end
      if (k == PH_RD) st_nxt[k].phase = PH_W'(0) - st_r[k-1].z;
      if (k == PH_WR) begin
        prev = !st_r[k-1].inmem ? '0 : (fw_r ? fwd_r : rd_r);
        st_nxt[k].diff = st_r[k-1].nz ? (st_r[k-1].phase - prev) : '0;
      end
      if (k == MUL_ST) begin
        pa_s = $signed(st_r[k-1].diff) * $signed({1'b0, cfg.angle_to_hz});
        st_nxt[k].pa = pa_s;
        st_nxt[k].pb = st_r[k-1].bin * cfg.bin_spacing_hz;
      end
      if (k == FRQ_ST) begin
        s = $signed({st_r[k-1].pa[PH_W+CFG_W], st_r[k-1].pa})
          + $signed({2'b00, (PH_W-BIN_W)'(0), st_r[k-1].pb});
        if (s > $signed({{(PH_W+2){1'b0}}, 32'h7FFF_FFFF}))
          st_nxt[k].freq = 32'h7FFF_FFFF;
        else if (s < $signed({{(PH_W+2){1'b1}}, 32'h8000_0000}))
          st_nxt[k].freq = 32'h8000_0000;
        else
          st_nxt[k].freq = s[FREQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      if (en) vld_r <= {vld_r[NSTAGE-2:0], item_vld};
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
        if (clr_cnt_r == MEM_AW'(MEM_DEPTH-1)) clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTAGE; k++) st_r[k] <= st_nxt[k];
      rd_r  <= mem[rd_addr];
      fw_r  <= fw_nxt;
      fwd_r <= st_r[PH_RD].phase;
    end
    if (clr_busy_r)  mem[clr_cnt_r] <= '0;
    else if (wr_en)  mem[wr_addr]   <= st_r[PH_RD].phase;
  end

  assign res_push = en && vld_r[NSTAGE-1];
  assign res.mag  = st_r[NSTAGE-1].q;
  assign res.freq = st_r[NSTAGE-1].freq;
  assign res.bin  = st_r[NSTAGE-1].bin;
  assign res.last = st_r[NSTAGE-1].last;

endmodule
`default_nettype wire

// File: src/pva_outq.sv
// Result queue between the back end and the output port.
// Depends on pva_pkg.
`default_nettype none
module pva_outq import pva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pva_result_t din,
  output logic        room,
  output logic        empty,
  input  logic        pop,
  output pva_result_t dout
);

  pva_result_t    q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r;
  logic           do_pop;

  assign room   = (cnt_r != QCW'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign dout   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)   wp_r <= wp_r + QAW'(1);
      if (do_pop) rp_r <= rp_r + QAW'(1);
      if (push && !do_pop)      cnt_r <= cnt_r + QCW'(1);
      else if (do_pop && !push) cnt_r <= cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= din;
  end

endmodule
`default_nettype wire

// File: src/phase_vocoder_analysis.sv
// Top level of the phase vocoder analysis block: config registers, front end,
// back end and result queue. Depends on pva_pkg, pva_front, pva_back, pva_outq.
//
// One FFT bin goes in per word (real, imag, bin number); one word comes out with
// magnitude, Q16.16 instantaneous frequency, bin number and a last flag for the
// Nyquist bin. Throughput is one bin per clock while the result queue has room;
// the back end is a 26-stage pipeline (24 square-root digit stages set the
// length, the 15 CORDIC stages run alongside). A bin accepted by the input
// queue steps through the back-end register sets and is then written into the
// result queue, from which it shows on the out_ ports.
// The whole back end stalls as a unit when the result queue is full. After
// reset the per-bin phase memory (513 x 16) is cleared one entry per cycle:
// in_full stays high until the clear is done; config writes are taken meanwhile.
// Config is written through cfg_* (cfg_ready is always high) and must only
// change while no bins are in flight.
`default_nettype none
module phase_vocoder_analysis import pva_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [SAMP_W-1:0] in_real_part,
  input  logic signed [SAMP_W-1:0] in_imag_part,
  input  logic [BIN_W-1:0]         in_bin_index,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [MAG_W-1:0]         out_magnitude,
  output logic signed [FREQ_W-1:0] out_frequency,
  output logic [BIN_W-1:0]         out_bin_out,
  output logic                     out_last_bin,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  pva_cfg_t    cfg_r;
  pva_item_t   item;
  pva_result_t res, head;
  logic        item_vld, item_pop, res_push, res_room, clr_busy;

  // config registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_size      <= HALF_SIZE_RST;
      cfg_r.bin_spacing_hz <= BIN_SPACING_RST;
      cfg_r.angle_to_hz    <= ANGLE_TO_HZ_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HALF_SIZE:   cfg_r.half_size      <= cfg_data[BIN_W-1:0];
        CFG_BIN_SPACING: cfg_r.bin_spacing_hz <= cfg_data;
        CFG_ANGLE_TO_HZ: cfg_r.angle_to_hz    <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: mask imag at DC/Nyquist, tag last bin, queue
  pva_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .real_part (in_real_part),
    .imag_part (in_imag_part),
    .bin_index (in_bin_index),
    .half_size (cfg_r.half_size),
    .clr_busy  (clr_busy),
    .item_vld  (item_vld),
    .item      (item),
    .item_pop  (item_pop)
  );

  // back: magnitude, angle, phase advance, frequency
  pva_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .item_vld (item_vld),
    .item     (item),
    .item_pop (item_pop),
    .res_room (res_room),
    .res_push (res_push),
    .res      (res),
    .clr_busy (clr_busy)
  );

  pva_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .room  (res_room),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (head)
  );

  assign out_magnitude = head.mag;
  assign out_frequency = head.freq;
  assign out_bin_out   = head.bin;
  assign out_last_bin  = head.last;

endmodule
`default_nettype wire

// File: src/pva_checker.sv
// Port-level checks for phase_vocoder_analysis, bound to the top level.
// Depends on pva_pkg.
`default_nettype none
module pva_checker import pva_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_full,
  input logic                     out_empty,
  input logic                     out_pop,
  input logic [MAG_W-1:0]         out_magnitude,
  input logic signed [FREQ_W-1:0] out_frequency
);

  // phase memory clear holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> in_full) else $error("input open during phase clear");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty) else $error("result present after reset");

  // largest possible magnitude is floor(sqrt(2 * 2^46))
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_magnitude <= 24'd11863283) else $error("magnitude out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_magnitude)
                                  && $stable(out_frequency)))
    else $error("result word changed while waiting");

endmodule

bind phase_vocoder_analysis pva_checker u_pva_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_magnitude (out_magnitude),
  .out_frequency (out_frequency)
);
`default_nettype wire
